// ===== hw/rtl/key_stack_with_remove_matching_top_defines.svh =====
// ----------------------------------------------------------------------------
// Key stack assertion macros
// Concurrent assertion helpers clocked on clock, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef KEY_STACK_WITH_REMOVE_MATCHING_TOP_DEFINES_SVH
`define KEY_STACK_WITH_REMOVE_MATCHING_TOP_DEFINES_SVH

// same-cycle implication
`define KSRM_ASSERT_NOW(label, cond, consq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (consq)) \
      else $error(msg);

// next-cycle implication
`define KSRM_ASSERT_NEXT(label, cond, consq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (consq)) \
      else $error(msg);

`endif

// ===== hw/rtl/ksrm_pkg.sv =====
// ----------------------------------------------------------------------------
// Key stack package
// Sizes, codes and shared types of the key stack with remove-by-value.
// ----------------------------------------------------------------------------
`default_nettype none

package ksrm_pkg;

   localparam int DEPTH     = 16;
   localparam int KEY_BITS  = 64;
   localparam int KEY_W     = 64;
   localparam int OUT_CNT_W = 5;
   localparam int CNT_BITS  = $clog2(DEPTH + 1);
   localparam int IDX_BITS  = $clog2(DEPTH);

   localparam logic [1:0] ACT_PUSH   = 2'd0;
   localparam logic [1:0] ACT_POP    = 2'd1;
   localparam logic [1:0] ACT_REMOVE = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_PUSH,
      CELL_POP,
      CELL_RMV
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        sel;
   } cell_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]           status;
      logic [KEY_W-1:0]     popped;
      logic [OUT_CNT_W-1:0] depth;
      logic [OUT_CNT_W-1:0] removed;
   } result_type;

endpackage

`default_nettype wire

// ===== hw/rtl/ksrm_cell.sv =====
// ----------------------------------------------------------------------------
// Key stack cell
// One stack slot; cell 0 is the top. Takes its upper neighbor on push, its
// lower neighbor on pop and compaction, or the head entry when selected.
// ----------------------------------------------------------------------------
`default_nettype none

module ksrm_cell
   import ksrm_pkg::*;
(
   input  wire logic                clock,
   input  wire cell_ctl_type        ctl,
   input  wire logic [KEY_BITS-1:0] toward_top_d,
   input  wire logic [KEY_BITS-1:0] toward_bottom_d,
   input  wire logic [KEY_BITS-1:0] head_d,
   output logic      [KEY_BITS-1:0] q
);

   logic [KEY_BITS-1:0] data_ff;
   logic [KEY_BITS-1:0] data_in;

   always_comb begin
      case (ctl.op)
         CELL_PUSH: data_in = toward_top_d;
         CELL_POP:  data_in = toward_bottom_d;
         CELL_RMV:  data_in = ctl.sel ? head_d : toward_bottom_d;
         default:   data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign q = data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/ksrm_ctrl.sv =====
// ----------------------------------------------------------------------------
// Key stack controller
// Depth count, removal walk sequencing and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ksrm_ctrl
   import ksrm_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [1:0]           req_action,
   input  wire logic [KEY_W-1:0]     req_key,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output result_type                rsp_result,
   input  wire logic [KEY_BITS-1:0]  head_q,
   output cell_op_type               cell_op,
   output logic      [DEPTH-1:0]     cell_sel
);

   state_type             state_ff, state_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [CNT_BITS-1:0]   rem_ff, rem_in;
   logic [CNT_BITS-1:0]   kept_ff, kept_in;
   logic [CNT_BITS-1:0]   removed_ff, removed_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   result_type            res_ff, res_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   result_type            rsp_ff, rsp_in;

   logic                  accept;
   logic                  rsp_load;
   logic                  match;
   logic [CNT_BITS-1:0]   wr_pos;
   logic [CNT_BITS-1:0]   kept_next;
   logic [CNT_BITS-1:0]   removed_next;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);

   assign match        = (head_q == key_ff);
   assign wr_pos       = rem_ff - CNT_BITS'(1) + kept_ff;
   assign kept_next    = kept_ff + (match ? CNT_BITS'(0) : CNT_BITS'(1));
   assign removed_next = removed_ff + (match ? CNT_BITS'(1) : CNT_BITS'(0));

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      rem_in     = rem_ff;
      kept_in    = kept_ff;
      removed_in = removed_ff;
      key_in     = key_ff;
      res_in     = res_ff;
      cell_op    = CELL_HOLD;
      cell_sel   = '0;
      rsp_load   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_in.status  = ST_OK;
               res_in.popped  = '0;
               res_in.removed = '0;
               res_in.depth   = OUT_CNT_W'(count_ff);
               state_in       = ST_DONE;
               case (req_action)
                  ACT_PUSH: begin
                     if (count_ff >= CNT_BITS'(DEPTH)) begin
                        res_in.status = ST_FULL;
                     end else begin
                        cell_op      = CELL_PUSH;
                        count_in     = count_ff + CNT_BITS'(1);
                        res_in.depth = OUT_CNT_W'(count_ff + CNT_BITS'(1));
                     end
                  end
                  ACT_POP: begin
                     if (count_ff == '0) begin
                        res_in.status = ST_EMPTY;
                     end else begin
                        cell_op       = CELL_POP;
                        count_in      = count_ff - CNT_BITS'(1);
                        res_in.depth  = OUT_CNT_W'(count_ff - CNT_BITS'(1));
                        res_in.popped = KEY_W'(head_q);
                     end
                  end
                  ACT_REMOVE: begin
                     key_in     = req_key[KEY_BITS-1:0];
                     rem_in     = count_ff;
                     kept_in    = '0;
                     removed_in = '0;
                     if (count_ff != '0) begin
                        state_in = ST_WALK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WALK: begin
            cell_op = CELL_RMV;
            if (!match) begin
               cell_sel = DEPTH'(1) << wr_pos[IDX_BITS-1:0];
            end
            rem_in     = rem_ff - CNT_BITS'(1);
            kept_in    = kept_next;
            removed_in = removed_next;
            if (rem_ff == CNT_BITS'(1)) begin
               count_in       = kept_next;
               res_in.status  = ST_OK;
               res_in.popped  = '0;
               res_in.depth   = OUT_CNT_W'(kept_next);
               res_in.removed = OUT_CNT_W'(removed_next);
               state_in       = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   assign rsp_in       = rsp_load ? res_ff : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      kept_ff    <= kept_in;
      removed_ff <= removed_in;
      key_ff     <= key_in;
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/key_stack_with_remove_matching_top.sv =====
// ----------------------------------------------------------------------------
// Key stack with remove-by-value, top level
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  action, key
//   rsp      out        rsp_valid / rsp_stall  status, popped_key, depth,
//                                              removed_count
//
// Push, pop and idle codes: the result is registered, then loaded into the
// rsp register once it is free. Remove walks all N held entries (at most
// DEPTH), one entry rotates past the head comparator per cycle.
// Synchronous reset empties the stack; slot contents are not cleared.
// A new request transfers while an earlier result is still stalled; the
// next result then waits in the controller until the rsp register drains.
// ----------------------------------------------------------------------------
`default_nettype none

`include "key_stack_with_remove_matching_top_defines.svh"

module key_stack_with_remove_matching_top
   import ksrm_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [1:0]           req_action,
   input  wire logic [KEY_W-1:0]     req_key,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [1:0]                rsp_status,
   output logic [KEY_W-1:0]          rsp_popped_key,
   output logic [OUT_CNT_W-1:0]      rsp_depth,
   output logic [OUT_CNT_W-1:0]      rsp_removed_count
);

   logic [KEY_BITS-1:0] cell_q [DEPTH];
   cell_op_type         cell_op;
   logic [DEPTH-1:0]    cell_sel;
   result_type          rsp_result;

   ksrm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_action (req_action),
      .req_key    (req_key),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_result (rsp_result),
      .head_q     (cell_q[0]),
      .cell_op    (cell_op),
      .cell_sel   (cell_sel)
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      cell_ctl_type        ctl;
      logic [KEY_BITS-1:0] top_side;
      logic [KEY_BITS-1:0] bottom_side;

      assign ctl.op  = cell_op;
      assign ctl.sel = cell_sel[i];

      if (i == 0) begin : g_first
         assign top_side = req_key[KEY_BITS-1:0];
      end else begin : g_inner
         assign top_side = cell_q[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign bottom_side = cell_q[i];
      end else begin : g_upper
         assign bottom_side = cell_q[i+1];
      end

      ksrm_cell u_cell (
         .clock           (clock),
         .ctl             (ctl),
         .toward_top_d    (top_side),
         .toward_bottom_d (bottom_side),
         .head_d          (cell_q[0]),
         .q               (cell_q[i])
      );
   end

   assign rsp_status        = rsp_result.status;
   assign rsp_popped_key    = rsp_result.popped;
   assign rsp_depth         = rsp_result.depth;
   assign rsp_removed_count = rsp_result.removed;

   `KSRM_ASSERT_NOW(a_depth_bound, rsp_valid, rsp_depth <= OUT_CNT_W'(DEPTH), "depth over bound")
   `KSRM_ASSERT_NOW(a_removed_excl, rsp_valid && (rsp_removed_count != '0),
      (rsp_status == ST_OK) && (rsp_popped_key == '0), "removed count with pop or error")
   `KSRM_ASSERT_NEXT(a_busy_after_xfer, req_valid && !req_stall, req_stall,
      "request transfer not followed by busy")
   `KSRM_ASSERT_NOW(a_walk_busy, cell_op == CELL_RMV, req_stall, "compaction while idle")

endmodule

`default_nettype wire

// ===== tb/sv/key_stack_checker.sv =====
// ----------------------------------------------------------------------------
// Key stack checker
// Watches both channels of the key stack. Every request transfer updates a
// private copy of the stack and queues the result it must produce. Every
// result transfer is compared field by field with the oldest queued result.
// ----------------------------------------------------------------------------
module key_stack_checker
   import ksrm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic [1:0]           req_action,
   input  logic [KEY_W-1:0]     req_key,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [1:0]           rsp_status,
   input  logic [KEY_W-1:0]     rsp_popped_key,
   input  logic [OUT_CNT_W-1:0] rsp_depth,
   input  logic [OUT_CNT_W-1:0] rsp_removed_count,
   output int                   fail_count,
   output int                   outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [KEY_BITS-1:0] held [DEPTH];
   int                  held_count;
   result_type          due_results [$];
   int                  errors;

   initial begin
      held_count  = 0;
      errors      = 0;
      fail_count  = 0;
      outstanding = 0;
   end

   task automatic report_mismatch(string msg);
      if (errors < 100) begin
         $display("[%0t] mismatch: %s", $time, msg);
      end
      errors++;
   endtask

   // Apply one request to the stack copy and return the result it yields.
   function automatic result_type stack_apply(logic [1:0] action,
                                              logic [KEY_W-1:0] key_in);
      logic [KEY_BITS-1:0] key;
      result_type          r;
      int                  keep;
      key = key_in[KEY_BITS-1:0];
      r   = '0;
      case (action)
         ACT_PUSH: begin
            if (held_count >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               held[held_count] = key;
               held_count++;
            end
         end
         ACT_POP: begin
            if (held_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               held_count--;
               r.popped = KEY_W'(held[held_count]);
            end
         end
         ACT_REMOVE: begin
            keep = 0;
            for (int i = 0; i < held_count; i++) begin
               if (held[i] == key) begin
                  r.removed = r.removed + 1'b1;
               end else begin
                  held[keep] = held[i];
                  keep++;
               end
            end
            held_count = keep;
         end
         default: ;
      endcase
      r.depth = OUT_CNT_W'(held_count);
      return r;
   endfunction

   always @(posedge clock) begin
      result_type exp;
      if (reset) begin
         held_count = 0;
         due_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_results.size() == 0) begin
               report_mismatch($sformatf("result with none pending: status %0d depth %0d",
                                         rsp_status, rsp_depth));
            end else begin
               exp = due_results.pop_front();
               if (rsp_status !== exp.status)
                  report_mismatch($sformatf("status got %0d want %0d",
                                            rsp_status, exp.status));
               if (rsp_popped_key !== exp.popped)
                  report_mismatch($sformatf("popped_key got %h want %h",
                                            rsp_popped_key, exp.popped));
               if (rsp_depth !== exp.depth)
                  report_mismatch($sformatf("depth got %0d want %0d",
                                            rsp_depth, exp.depth));
               if (rsp_removed_count !== exp.removed)
                  report_mismatch($sformatf("removed_count got %0d want %0d",
                                            rsp_removed_count, exp.removed));
            end
         end
         if (req_valid && !req_stall) begin
            due_results.push_back(stack_apply(req_action, req_key));
         end
      end
      outstanding <= due_results.size();
      fail_count  <= errors;
   end

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// Key stack testbench
// Drives a short directed sequence (empty pop and remove, unused action,
// fill to full with extreme and repeated keys, refused push, matching and
// non-matching removes, pops), then random episodes of push, pop and remove
// over small key pools so that removes find matches and the stack fills.
// Both channels idle in random bursts; the tail of the run has no idling.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ksrm_pkg::*;

   localparam logic [1:0] ACT_NOP     = 2'd3;
   localparam int         ITEMS       = 1950;
   localparam int         QUIET_ITEMS = 150;
   localparam int         LIMIT       = 1000000;
   localparam int         DRAIN       = 40;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_valid  = 1'b0;
   logic [1:0]           req_action = ACT_PUSH;
   logic [KEY_W-1:0]     req_key    = '0;
   logic                 rsp_stall  = 1'b0;
   logic                 req_stall;
   logic                 rsp_valid;
   logic [1:0]           rsp_status;
   logic [KEY_W-1:0]     rsp_popped_key;
   logic [OUT_CNT_W-1:0] rsp_depth;
   logic [OUT_CNT_W-1:0] rsp_removed_count;
   int                   fail_count;
   int                   outstanding;

   bit gaps_on   = 1'b0;
   bit idling_on = 1'b0;
   int stall_left = 0;
   int sent       = 0;
   int cycle_count = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   key_stack_with_remove_matching_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_key           (req_key),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_popped_key    (rsp_popped_key),
      .rsp_depth         (rsp_depth),
      .rsp_removed_count (rsp_removed_count)
   );

   key_stack_checker stack_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_key           (req_key),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_popped_key    (rsp_popped_key),
      .rsp_depth         (rsp_depth),
      .rsp_removed_count (rsp_removed_count),
      .fail_count        (fail_count),
      .outstanding       (outstanding)
   );

   // result-side stall bursts, started at random while idling is on
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 15);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   initial begin
      while (cycle_count < LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   task automatic set_idling(bit on);
      gaps_on = on;
      idling_on <= on;
   endtask

   // Present one request, hold it until it transfers, then maybe idle.
   task automatic send_item(logic [1:0] action, logic [KEY_W-1:0] key);
      if (gaps_on && sent >= ITEMS - QUIET_ITEMS) set_idling(1'b0);
      req_valid  <= 1'b1;
      req_action <= action;
      req_key    <= key;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   function automatic logic [KEY_W-1:0] wide_key();
      return {$urandom, $urandom};
   endfunction

   // lowercase string of 1 to 8 characters, zero padded
   function automatic logic [KEY_W-1:0] text_key();
      logic [KEY_W-1:0] k;
      int               n;
      k = '0;
      n = $urandom_range(1, KEY_W / 8);
      for (int i = 0; i < n; i++) k[i*8 +: 8] = 8'($urandom_range(97, 122));
      return k;
   endfunction

   initial begin
      logic [KEY_W-1:0] fill_keys [16];
      logic [KEY_W-1:0] pool [4];
      logic [KEY_W-1:0] key;
      logic [1:0]       act;
      int               pool_n;
      int               push_pct;
      int               roll;

      fill_keys = '{'1, '0, 64'h636261, '1, 64'h8000_0000_0000_0000, 64'h636261,
                    '1, 64'h7965_6b6b_6361_7473, '0, 64'h1, 64'h636261,
                    64'h7fff_ffff_ffff_ffff, 64'hff, 64'h6162, '1, 64'h0100_0000_0000_0000};

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed
      set_idling(1'b1);
      send_item(ACT_POP, '0);
      send_item(ACT_REMOVE, 64'h636261);
      send_item(ACT_NOP, '1);
      foreach (fill_keys[i]) send_item(ACT_PUSH, fill_keys[i]);
      send_item(ACT_PUSH, '1);
      send_item(ACT_NOP, '0);
      send_item(ACT_REMOVE, '1);
      send_item(ACT_REMOVE, 64'h7a7978);
      send_item(ACT_POP, '0);
      send_item(ACT_POP, '0);

      // random episodes
      while (sent < ITEMS) begin
         pool_n = $urandom_range(1, 4);
         for (int i = 0; i < pool_n; i++) pool[i] = $urandom_range(0, 1) ? text_key() : wide_key();
         set_idling(sent < ITEMS - QUIET_ITEMS && $urandom_range(0, 3) != 0);
         if ($urandom_range(0, 4) == 0) begin
            // fill with one key, then flush it
            repeat ($urandom_range(16, 18)) send_item(ACT_PUSH, pool[0]);
            send_item(ACT_REMOVE, pool[0]);
         end else begin
            push_pct = $urandom_range(30, 85);
            repeat ($urandom_range(8, 40)) begin
               roll = $urandom_range(0, 99);
               key  = ($urandom_range(0, 4) == 0) ? wide_key() : pool[$urandom_range(0, pool_n - 1)];
               if (roll < push_pct)
                  act = ACT_PUSH;
               else if (roll < push_pct + (100 - push_pct) / 2)
                  act = ACT_POP;
               else if (roll < 97)
                  act = ACT_REMOVE;
               else
                  act = ACT_NOP;
               send_item(act, key);
            end
         end
      end
      set_idling(1'b0);
      req_valid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
